@@ hdl/assert_macros.svh @@
// Assertion macros for the frame rate monitor RTL.
// Depends on nothing; included by frame_rate_monitor.sv, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check under reset qualification.
`define FRM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every edge, reset included.
`define FRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ hdl/frm_pkg.sv @@
// Package of the frame rate monitor: widths, constants, state codes and
// the status structs passed between the top level and its serial units.
`default_nettype none

package frm_pkg;

    localparam int WINDOW   = 16;
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SEEN_W   = $clog2(WINDOW + 1);
    localparam int CNT_W    = 16;
    localparam int SUM_W    = CNT_W + PTR_W;
    localparam int TOT_W    = 32;
    localparam int TS_W     = 63;
    localparam int IVL_W    = 40;
    localparam int AVG_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int DIV_W    = SUM_W + FRAC_W;
    localparam int DIVCNT_W = $clog2(DIV_W);

    localparam int CMP_W      = 64;
    localparam int DIG_W      = 4;
    localparam int CMP_DIGITS = CMP_W / DIG_W;
    localparam int DIGCNT_W   = $clog2(CMP_DIGITS);

    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(1000000000);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic done;
        logic ge;
    } cmp_stat_t;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

@@ hdl/frm_cmp.sv @@
// Digit-serial check of timestamp >= interval start + interval length.
// Adds and compares one 4-bit digit per cycle, LSB first. Uses frm_pkg.
`default_nettype none

module frm_cmp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [frm_pkg::TS_W-1:0]   ts,
    input  wire logic [frm_pkg::TS_W-1:0]   base,
    input  wire logic [frm_pkg::IVL_W-1:0]  ivl,
    output frm_pkg::cmp_stat_t              stat
);

    logic [frm_pkg::CMP_W-1:0]    ts_reg, ts_next;
    logic [frm_pkg::CMP_W-1:0]    base_reg, base_next;
    logic [frm_pkg::CMP_W-1:0]    ivl_reg, ivl_next;
    logic                         carry_reg, carry_next;
    logic                         ge_reg, ge_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [frm_pkg::DIGCNT_W-1:0] cnt_reg, cnt_next;

    logic [frm_pkg::DIG_W:0]      dsum;
    logic [frm_pkg::DIG_W-1:0]    sdig;
    logic [frm_pkg::DIG_W-1:0]    tdig;

    assign dsum = {1'b0, base_reg[frm_pkg::DIG_W-1:0]}
                + {1'b0, ivl_reg[frm_pkg::DIG_W-1:0]}
                + {{frm_pkg::DIG_W{1'b0}}, carry_reg};
    assign sdig = dsum[frm_pkg::DIG_W-1:0];
    assign tdig = ts_reg[frm_pkg::DIG_W-1:0];

    always_comb begin
        ts_next    = ts_reg;
        base_next  = base_reg;
        ivl_next   = ivl_reg;
        carry_next = carry_reg;
        ge_next    = ge_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        if (start) begin
            ts_next    = {{(frm_pkg::CMP_W - frm_pkg::TS_W){1'b0}}, ts};
            base_next  = {{(frm_pkg::CMP_W - frm_pkg::TS_W){1'b0}}, base};
            ivl_next   = {{(frm_pkg::CMP_W - frm_pkg::IVL_W){1'b0}}, ivl};
            carry_next = 1'b0;
            ge_next    = 1'b1;
            busy_next  = 1'b1;
            cnt_next   = '0;
        end else if (busy_reg) begin
            ts_next    = ts_reg >> frm_pkg::DIG_W;
            base_next  = base_reg >> frm_pkg::DIG_W;
            ivl_next   = ivl_reg >> frm_pkg::DIG_W;
            carry_next = dsum[frm_pkg::DIG_W];
            ge_next    = (tdig > sdig) || ((tdig == sdig) && ge_reg);
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == frm_pkg::DIGCNT_W'(frm_pkg::CMP_DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
            ge_reg    <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            carry_reg <= carry_next;
            ge_reg    <= ge_next;
        end
        ts_reg   <= ts_next;
        base_reg <= base_next;
        ivl_reg  <= ivl_next;
    end

    assign stat.done = done_reg;
    assign stat.ge   = ge_reg;

endmodule

`default_nettype wire

@@ hdl/frm_div.sv @@
// Bit-serial restoring divider for the window average, one quotient bit
// per cycle, saturated to the Q8 output width. Uses frm_pkg.
`default_nettype none

module frm_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [frm_pkg::SUM_W-1:0]   sum,
    input  wire logic [frm_pkg::SEEN_W-1:0]  count,
    output frm_pkg::div_stat_t               stat
);

    logic [frm_pkg::DIV_W-1:0]    num_reg, num_next;
    logic [frm_pkg::SEEN_W-1:0]   den_reg, den_next;
    logic [frm_pkg::SEEN_W-1:0]   rem_reg, rem_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [frm_pkg::DIVCNT_W-1:0] cnt_reg, cnt_next;

    logic [frm_pkg::SEEN_W:0]     trial;
    logic [frm_pkg::SEEN_W:0]     diff;
    logic                         qbit;

    assign trial = {rem_reg, num_reg[frm_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            num_next  = {sum, {frm_pkg::FRAC_W{1'b0}}};
            den_next  = count;
            rem_next  = '0;
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[frm_pkg::SEEN_W-1:0] : trial[frm_pkg::SEEN_W-1:0];
            num_next = {num_reg[frm_pkg::DIV_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == frm_pkg::DIVCNT_W'(frm_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = (|num_reg[frm_pkg::DIV_W-1:frm_pkg::AVG_W])
                         ? {frm_pkg::AVG_W{1'b1}} : num_reg[frm_pkg::AVG_W-1:0];

endmodule

`default_nettype wire

@@ hdl/frame_rate_monitor.sv @@
// Top level of the frame rate monitor: control sequencer, counters, sample
// ring and output register. Uses frm_pkg, frm_cmp, frm_div, assert_macros.svh.
//
//  channel   prefix  direction  word
//  input     s_      in         one frame timestamp
//  result    m_      out        close flag, interval count, average, total
//  config    cfg_    in         interval length in ns
//
// A frame that leaves its interval open has its word loaded after the 16-digit
// serial compare; a frame that closes an interval goes on through the ring
// update state and the 28-step divider first. The sequencer returns to idle,
// ready for the next frame, as the word loads.
// Reset clears counters, interval start, sample ring and sum.
// s_ready is high only while the sequencer is idle; a finished word waits
// in the output register, and the next frame is taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module frame_rate_monitor (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [frm_pkg::TS_W-1:0]     s_timestamp_ns,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_interval_closed,
    output logic [frm_pkg::CNT_W-1:0]         m_frames_in_interval,
    output logic [frm_pkg::AVG_W-1:0]         m_average_fps_q8,
    output logic [frm_pkg::TOT_W-1:0]         m_total_frame_count,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [frm_pkg::IVL_W-1:0]    cfg_interval_ns
);

    frm_pkg::state_t              state_reg, state_next;
    logic [frm_pkg::IVL_W-1:0]    ivl_reg, ivl_next;
    logic [frm_pkg::TS_W-1:0]     ts_reg, ts_next;
    logic [frm_pkg::TS_W-1:0]     start_reg, start_next;
    logic [frm_pkg::CNT_W-1:0]    frames_reg, frames_next;
    logic [frm_pkg::TOT_W-1:0]    total_reg, total_next;
    logic [frm_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [frm_pkg::PTR_W-1:0]    ptr_reg, ptr_next;
    logic [frm_pkg::SEEN_W-1:0]   seen_reg, seen_next;
    logic                         closed_reg, closed_next;
    logic [frm_pkg::CNT_W-1:0]    ccnt_reg, ccnt_next;
    logic [frm_pkg::AVG_W-1:0]    avg_reg, avg_next;
    logic [frm_pkg::CNT_W-1:0]    ring_reg [frm_pkg::WINDOW];
    logic                         ring_we;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_closed_reg, m_closed_next;
    logic [frm_pkg::CNT_W-1:0]    m_frames_reg, m_frames_next;
    logic [frm_pkg::AVG_W-1:0]    m_avg_reg, m_avg_next;
    logic [frm_pkg::TOT_W-1:0]    m_total_reg, m_total_next;

    logic                         cmp_start;
    logic                         div_start;
    frm_pkg::cmp_stat_t           cmp_stat;
    frm_pkg::div_stat_t           div_stat;

    frm_cmp u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmp_start),
        .ts      (s_timestamp_ns),
        .base    (start_reg),
        .ivl     (ivl_reg),
        .stat    (cmp_stat)
    );

    frm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (sum_next),
        .count   (seen_next),
        .stat    (div_stat)
    );

    assign s_ready   = (state_reg == frm_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next    = state_reg;
        ivl_next      = (cfg_valid && cfg_ready) ? cfg_interval_ns : ivl_reg;
        ts_next       = ts_reg;
        start_next    = start_reg;
        frames_next   = frames_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        ptr_next      = ptr_reg;
        seen_next     = seen_reg;
        closed_next   = closed_reg;
        ccnt_next     = ccnt_reg;
        avg_next      = avg_reg;
        ring_we       = 1'b0;
        cmp_start     = 1'b0;
        div_start     = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_closed_next = m_closed_reg;
        m_frames_next = m_frames_reg;
        m_avg_next    = m_avg_reg;
        m_total_next  = m_total_reg;

        unique case (state_reg)
            frm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    ts_next     = s_timestamp_ns;
                    frames_next = (frames_reg == {frm_pkg::CNT_W{1'b1}})
                                ? frames_reg : frames_reg + 1'b1;
                    total_next  = total_reg + 1'b1;
                    cmp_start   = 1'b1;
                    state_next  = frm_pkg::ST_CMP;
                end
            end
            frm_pkg::ST_CMP: begin
                if (cmp_stat.done) begin
                    closed_next = cmp_stat.ge;
                    if (cmp_stat.ge) begin
                        state_next = frm_pkg::ST_UPD;
                    end else begin
                        ccnt_next  = '0;
                        avg_next   = '0;
                        state_next = frm_pkg::ST_OUT;
                    end
                end
            end
            frm_pkg::ST_UPD: begin
                sum_next    = sum_reg - {{frm_pkg::PTR_W{1'b0}}, ring_reg[ptr_reg]}
                            + {{frm_pkg::PTR_W{1'b0}}, frames_reg};
                ring_we     = 1'b1;
                ptr_next    = (ptr_reg == frm_pkg::PTR_W'(frm_pkg::WINDOW - 1))
                            ? '0 : ptr_reg + 1'b1;
                seen_next   = (seen_reg == frm_pkg::SEEN_W'(frm_pkg::WINDOW))
                            ? seen_reg : seen_reg + 1'b1;
                ccnt_next   = frames_reg;
                frames_next = '0;
                start_next  = ts_reg;
                div_start   = 1'b1;
                state_next  = frm_pkg::ST_DIV;
            end
            frm_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    avg_next   = div_stat.quotient;
                    state_next = frm_pkg::ST_OUT;
                end
            end
            frm_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_closed_next = closed_reg;
                    m_frames_next = ccnt_reg;
                    m_avg_next    = avg_reg;
                    m_total_next  = total_reg;
                    state_next    = frm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = frm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= frm_pkg::ST_IDLE;
            ivl_reg     <= frm_pkg::IVL_RESET;
            start_reg   <= '0;
            frames_reg  <= '0;
            total_reg   <= '0;
            sum_reg     <= '0;
            ptr_reg     <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < frm_pkg::WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            ivl_reg     <= ivl_next;
            start_reg   <= start_next;
            frames_reg  <= frames_next;
            total_reg   <= total_next;
            sum_reg     <= sum_next;
            ptr_reg     <= ptr_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
            if (ring_we) begin
                ring_reg[ptr_reg] <= frames_reg;
            end
        end
        ts_reg       <= ts_next;
        closed_reg   <= closed_next;
        ccnt_reg     <= ccnt_next;
        avg_reg      <= avg_next;
        m_closed_reg <= m_closed_next;
        m_frames_reg <= m_frames_next;
        m_avg_reg    <= m_avg_next;
        m_total_reg  <= m_total_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_interval_closed    = m_closed_reg;
    assign m_frames_in_interval = m_frames_reg;
    assign m_average_fps_q8     = m_avg_reg;
    assign m_total_frame_count  = m_total_reg;

    `FRM_ASSERT(a_open_word_zero, aclk, aresetn, m_valid_reg && !m_closed_reg |-> m_frames_reg == '0 && m_avg_reg == '0, "open interval word carries a count or average")
    `FRM_ASSERT(a_cmp_done_state, aclk, aresetn, cmp_stat.done |-> state_reg == frm_pkg::ST_CMP, "compare finished outside its wait state")
    `FRM_ASSERT(a_div_done_state, aclk, aresetn, div_stat.done |-> state_reg == frm_pkg::ST_DIV, "divide finished outside its wait state")
    `FRM_ASSERT(a_seen_bound, aclk, aresetn, seen_reg <= frm_pkg::SEEN_W'(frm_pkg::WINDOW), "sample count beyond window")

endmodule

`default_nettype wire
